FILE: rtl/assert_macros.svh
// Assertion macros for the RTL of the tag stripper, included by the top-level unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock outside reset.
`define CHK_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// Next-cycle implication, checked on every clock outside reset.
`define CHK_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

FILE: rtl/tts_pkg.sv
// Package: types, character codes and region modes of the tag stripper.
package tts_pkg;

   localparam logic [7:0] CH_OPEN   = 8'h7B;
   localparam logic [7:0] CH_CLOSE  = 8'h7D;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_NL     = 8'h0A;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      MODE_TEXT    = 2'd0,
      MODE_SCRIPT  = 2'd1,
      MODE_ECHO    = 2'd2,
      MODE_COMMENT = 2'd3
   } region_mode_type;

   typedef struct packed {
      logic [7:0] in_char;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       has_char;
      logic       end_of_text;
   } rsp_type;

   // Work for the back part: one or two results caused by one item.
   typedef struct packed {
      logic [7:0] char_a;
      logic       has_a;
      logic       second;
      logic [7:0] char_b;
      logic       eot;
   } bundle_type;

   typedef struct packed {
      logic              full;
      logic              empty;
      logic [QCNT_W-1:0] count;
   } q_stat_type;

   function automatic logic [7:0] region_marker(region_mode_type mode);
      logic [7:0] mk;
      unique case (mode)
         MODE_SCRIPT: mk = CH_CLOSE;
         MODE_ECHO:   mk = CH_EQ;
         default:     mk = CH_HASH;
      endcase
      return mk;
   endfunction

endpackage

FILE: rtl/tts_front.sv
// Front part: tracks region state and turns each item into a result bundle.
module tts_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tts_pkg::req_type    req_data,
   input  tts_pkg::q_stat_type q_stat,
   output logic                push,
   output tts_pkg::bundle_type push_data
);
   import tts_pkg::*;

   region_mode_type mode_ff, mode_in, mode_nx;
   logic            pend_ff, pend_in, pend_nx;
   logic            drop_ff, drop_in, drop_nx;

   logic       fire;
   logic       skip;
   logic [7:0] c;
   logic       emit_a, emit_b, tail;
   logic [7:0] a_char;

   assign req_ready = !q_stat.full;
   assign fire      = req_valid && req_ready;
   assign c         = req_data.in_char;
   assign skip      = drop_ff && (c == CH_NL);

   // Next state, before the end-of-text reset.
   always_comb begin
      mode_nx = mode_ff;
      pend_nx = pend_ff;
      drop_nx = 1'b0;
      if (!skip) begin
         if (mode_ff == MODE_TEXT) begin
            if (pend_ff) begin
               pend_nx = 1'b0;
               unique case (c)
                  CH_OPEN: mode_nx = MODE_SCRIPT;
                  CH_EQ:   mode_nx = MODE_ECHO;
                  CH_HASH: mode_nx = MODE_COMMENT;
                  default: mode_nx = MODE_TEXT;
               endcase
            end else if (c == CH_OPEN) begin
               pend_nx = 1'b1;
            end
         end else begin
            if (pend_ff) begin
               pend_nx = 1'b0;
               if (c == CH_CLOSE) begin
                  mode_nx = MODE_TEXT;
                  drop_nx = 1'b1;
               end else if (c != CH_BSLASH && c == region_marker(mode_ff)) begin
                  pend_nx = 1'b1;
               end
            end else if (c == region_marker(mode_ff)) begin
               pend_nx = 1'b1;
            end
         end
      end
   end

   // Results caused by this item.
   always_comb begin
      emit_a = 1'b0;
      emit_b = 1'b0;
      a_char = c;
      if (!skip && mode_ff == MODE_TEXT) begin
         if (pend_ff) begin
            if (c != CH_OPEN && c != CH_EQ && c != CH_HASH) begin
               emit_a = 1'b1;
               a_char = CH_OPEN;
               emit_b = (c != CH_BSLASH);
            end
         end else if (c != CH_OPEN) begin
            emit_a = 1'b1;
         end
      end
      // Flush a held brace at end of text.
      tail = req_data.is_last && (mode_nx == MODE_TEXT) && pend_nx;
      push_data.char_a = emit_a ? a_char : (tail ? CH_OPEN : 8'h00);
      push_data.has_a  = emit_a || tail;
      push_data.second = emit_b;
      push_data.char_b = c;
      push_data.eot    = req_data.is_last;
      push             = fire && (emit_a || req_data.is_last);
   end

   // Return to plain text after the last byte.
   assign mode_in = req_data.is_last ? MODE_TEXT : mode_nx;
   assign pend_in = req_data.is_last ? 1'b0 : pend_nx;
   assign drop_in = req_data.is_last ? 1'b0 : drop_nx;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_TEXT;
         pend_ff <= 1'b0;
         drop_ff <= 1'b0;
      end else if (fire) begin
         mode_ff <= mode_in;
         pend_ff <= pend_in;
         drop_ff <= drop_in;
      end
   end

endmodule

FILE: rtl/tts_queue.sv
// Short bundle queue between the front and back parts.
module tts_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  tts_pkg::bundle_type push_data,
   input  logic                pop,
   output tts_pkg::bundle_type pop_data,
   output tts_pkg::q_stat_type q_stat
);
   import tts_pkg::*;

   bundle_type        slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
      logic [QPTR_W-1:0] r;
      if (p == QPTR_W'(QUEUE_DEPTH - 1)) r = '0;
      else r = p + QPTR_W'(1);
      return r;
   endfunction

   assign wr_ptr_in = push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
   assign rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + QCNT_W'(1);
      else if (pop && !push) count_in = count_ff - QCNT_W'(1);
   end

   assign pop_data     = slot_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign q_stat.count = count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/tts_back.sv
// Back part: unpacks bundles into result items through an output register.
module tts_back (
   input  logic                clock,
   input  logic                reset,
   input  tts_pkg::q_stat_type q_stat,
   input  tts_pkg::bundle_type pop_data,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output tts_pkg::rsp_type    rsp_data
);
   import tts_pkg::*;

   bundle_type cur_ff, cur_in;
   logic       valid_ff, valid_in;
   logic       phase_ff, phase_in;
   logic       fire;
   logic       more;

   assign fire = valid_ff && rsp_ready;
   assign more = !phase_ff && cur_ff.second;
   assign pop  = !q_stat.empty && (!valid_ff || (fire && !more));

   always_comb begin
      cur_in   = cur_ff;
      valid_in = valid_ff;
      phase_in = phase_ff;
      if (fire && more) begin
         phase_in = 1'b1;
      end else if (pop) begin
         cur_in   = pop_data;
         valid_in = 1'b1;
         phase_in = 1'b0;
      end else if (fire) begin
         valid_in = 1'b0;
         phase_in = 1'b0;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_data.out_char    = phase_ff ? cur_ff.char_b : cur_ff.char_a;
   assign rsp_data.has_char    = phase_ff ? 1'b1 : cur_ff.has_a;
   assign rsp_data.end_of_text = cur_ff.eot && (phase_ff || !cur_ff.second);

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
      end
   end

endmodule

FILE: rtl/template_tag_stripper_unit.sv
// Template tag stripper: drops script, echo and comment regions from a byte stream.
//
// Input channel req_*: one template byte per item, is_last marks the end of a text.
// Output channel rsp_*: rendered bytes; has_char=0 marks an end-only item, and
// end_of_text flags the final item caused by the last byte.
// An input item causes zero, one or two result items. The front part accepts
// one item per cycle while the queue is not full and writes its results as one
// bundle into a two-entry queue; the back part sends one result item per cycle
// from its output register while rsp_ready is high. An accepted item's bundle is
// written into the queue, then loaded into the output register that drives rsp_valid.
// Throughput: one input item per cycle while each causes at most one result and
// rsp_ready stays high; an item with two results sends them one after the other.
// When the receiver stalls, the output register and then the two queue entries
// fill, and req_ready drops; the front keeps its state until the next item is accepted.
// Reset: clears the queue and output register and returns to plain text;
// after a byte with is_last the region state also returns to plain text.
module template_tag_stripper_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tts_pkg::rsp_type rsp_data
);
   import tts_pkg::*;
   `include "assert_macros.svh"

   logic       push, pop;
   bundle_type push_data, pop_data;
   q_stat_type q_stat;

   tts_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .push      (push),
      .push_data (push_data)
   );

   tts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_stat    (q_stat)
   );

   tts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   `CHK_IMPLIES(a_queue_bound, clock, reset, 1'b1, q_stat.count <= QCNT_W'(QUEUE_DEPTH))
   `CHK_IMPLIES(a_no_push_full, clock, reset, q_stat.full, !push)
   `CHK_IMPLIES(a_marker_only_end, clock, reset, rsp_valid && !rsp_data.has_char,
                rsp_data.end_of_text && rsp_data.out_char == 8'h00)
   `CHK_NEXT(a_pop_loads, clock, reset, pop, rsp_valid)

endmodule

FILE: bench/tb_top.sv
// Testbench for the template tag stripper: directed and random templates, checked per result.
`timescale 1ns / 100ps

module tb_top;
   import tts_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 7;
   localparam int RANDOM_ITEMS = 1800;
   localparam int LONG_HOLD    = 400;
   localparam int HOLD_AFTER   = 500;
   localparam int TAIL_CYCLES  = 10;
   localparam int CYCLE_LIMIT  = 300000;

   // Tracks the stripper's state and the rendered bytes still owed by the block.
   class render_tracker;
      region_mode_type mode;
      logic            marker_held;
      logic            drop_nl;
      rsp_type         rendered_q[$];
      int              errors;

      function new();
         clear_state();
         errors = 0;
      endfunction

      function void clear_state();
         mode        = MODE_TEXT;
         marker_held = 1'b0;
         drop_nl     = 1'b0;
      endfunction

      function logic [7:0] closing_mark(region_mode_type m);
         case (m)
            MODE_SCRIPT: return CH_CLOSE;
            MODE_ECHO:   return CH_EQ;
            default:     return CH_HASH;
         endcase
      endfunction

      function rsp_type as_char(logic [7:0] c);
         return rsp_type'{out_char: c, has_char: 1'b1, end_of_text: 1'b0};
      endfunction

      function void absorb_byte(req_type item);
         rsp_type    fresh[$];
         logic [7:0] c;
         logic [7:0] mk;
         logic       skip;
         c    = item.in_char;
         skip = 1'b0;
         if (drop_nl) begin
            drop_nl = 1'b0;
            if (c == CH_NL) skip = 1'b1;
         end
         if (!skip) begin
            if (mode == MODE_TEXT) begin
               if (marker_held) begin
                  marker_held = 1'b0;
                  if (c == CH_OPEN) mode = MODE_SCRIPT;
                  else if (c == CH_EQ) mode = MODE_ECHO;
                  else if (c == CH_HASH) mode = MODE_COMMENT;
                  else begin
                     // release the held brace; a backslash after it is eaten
                     fresh.push_back(as_char(CH_OPEN));
                     if (c != CH_BSLASH) fresh.push_back(as_char(c));
                  end
               end else if (c == CH_OPEN) begin
                  marker_held = 1'b1;
               end else begin
                  fresh.push_back(as_char(c));
               end
            end else begin
               mk = closing_mark(mode);
               if (marker_held) begin
                  marker_held = 1'b0;
                  if (c == CH_CLOSE) begin
                     mode    = MODE_TEXT;
                     drop_nl = 1'b1;
                  end else if (c == mk) begin
                     marker_held = 1'b1;
                  end
               end else if (c == mk) begin
                  marker_held = 1'b1;
               end
            end
         end
         if (item.is_last) begin
            if (mode == MODE_TEXT && marker_held) fresh.push_back(as_char(CH_OPEN));
            if (fresh.size() == 0)
               fresh.push_back(rsp_type'{out_char: 8'h00, has_char: 1'b0, end_of_text: 1'b0});
            fresh[fresh.size() - 1].end_of_text = 1'b1;
            clear_state();
         end
         foreach (fresh[i]) rendered_q.push_back(fresh[i]);
      endfunction

      function void match_rendered(rsp_type got);
         rsp_type want;
         if (rendered_q.size() == 0) begin
            $error("result with nothing expected: out_char %h has_char %b end_of_text %b",
                   got.out_char, got.has_char, got.end_of_text);
            errors++;
            return;
         end
         want = rendered_q.pop_front();
         if (got.out_char !== want.out_char) begin
            $error("out_char: expected %h, actual %h", want.out_char, got.out_char);
            errors++;
         end
         if (got.has_char !== want.has_char) begin
            $error("has_char: expected %b, actual %b", want.has_char, got.has_char);
            errors++;
         end
         if (got.end_of_text !== want.end_of_text) begin
            $error("end_of_text: expected %b, actual %b", want.end_of_text, got.end_of_text);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   render_tracker tracker;
   req_type       template_bytes[$];
   int            accepted_items = 0;
   int            cycle_count = 0;

   template_tag_stripper_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Sample both handshakes with the values they held before the edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            tracker.absorb_byte(req_data);
            accepted_items++;
         end
         if (rsp_valid && rsp_ready) tracker.match_rendered(rsp_data);
      end
   end

   task automatic put_byte(logic [7:0] c);
      template_bytes.push_back(req_type'{in_char: c, is_last: 1'b0});
   endtask

   task automatic put_text(string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endtask

   task automatic finish_text();
      template_bytes[template_bytes.size() - 1].is_last = 1'b1;
   endtask

   function automatic logic [7:0] spicy_char();
      case ($urandom_range(0, 11))
         0:       return CH_OPEN;
         1:       return CH_CLOSE;
         2:       return CH_EQ;
         3:       return CH_HASH;
         4:       return CH_BSLASH;
         5:       return CH_NL;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == CH_OPEN);
      return c;
   endfunction

   task automatic put_region();
      int         kind;
      int         len;
      logic [7:0] mk;
      kind = $urandom_range(0, 2);
      put_byte(CH_OPEN);
      case (kind)
         0: begin
            put_byte(CH_OPEN);
            mk = CH_CLOSE;
         end
         1: begin
            put_byte(CH_EQ);
            mk = CH_EQ;
         end
         default: begin
            put_byte(CH_HASH);
            mk = CH_HASH;
         end
      endcase
      len = $urandom_range(0, 5);
      repeat (len) put_byte(spicy_char());
      if ($urandom_range(0, 3) == 0) begin
         put_byte(mk);
         put_byte(CH_BSLASH);
      end
      put_byte(mk);
      put_byte(CH_CLOSE);
      if ($urandom_range(0, 1) == 0) put_byte(CH_NL);
   endtask

   // Mostly well-formed templates with random content, some noise mixed in.
   task automatic put_template();
      int pieces;
      int len;
      pieces = $urandom_range(1, 8);
      repeat (pieces) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               len = $urandom_range(1, 6);
               repeat (len) put_byte(plain_char());
            end
            3, 4, 5, 6: put_region();
            7: begin
               put_byte(CH_OPEN);
               put_byte(CH_BSLASH);
            end
            8: begin
               put_byte(CH_OPEN);
               put_byte(8'($urandom_range(0, 255)));
            end
            default: begin
               len = $urandom_range(1, 4);
               repeat (len) put_byte(spicy_char());
            end
         endcase
      end
      case ($urandom_range(0, 9))
         8: begin
            // leave a region open at the end
            put_byte(CH_OPEN);
            put_byte(spicy_char() == CH_EQ ? CH_EQ : CH_OPEN);
            len = $urandom_range(0, 3);
            repeat (len) put_byte(plain_char());
         end
         9: put_byte(CH_OPEN);
         default: ;
      endcase
      finish_text();
   endtask

   task automatic offer_item(req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   initial begin : receiver
      int  mode_sel;
      int  stretch;
      int  beat;
      bit  held_long;
      rsp_ready <= 1'b0;
      held_long = 1'b0;
      beat      = 0;
      @(posedge clock);
      forever begin
         if (!held_long && accepted_items >= HOLD_AFTER) begin
            // hold off long enough for the block to fill and stall its input
            held_long = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            mode_sel = $urandom_range(0, 3);
            stretch  = $urandom_range(20, 200);
            repeat (stretch) begin
               case (mode_sel)
                  0:       rsp_ready <= 1'b1;
                  1:       rsp_ready <= ($urandom_range(0, 3) != 0);
                  2:       rsp_ready <= 1'($urandom_range(0, 1));
                  default: rsp_ready <= (beat % 3 != 0);
               endcase
               beat++;
               @(posedge clock);
            end
         end
      end
   end

   initial begin : main
      int burst;
      int gap;
      int directed_count;
      tracker = new();
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;

      // brace with backslash, brace with other byte, extreme byte values
      put_byte(8'h00);
      put_text("{\\");
      put_byte(CH_OPEN);
      put_byte(8'hFF);
      // script with marker then backslash, closer then newline dropped, second kept
      put_text("{{}\\}}\n\nb");
      // echo with repeated marker and swallowed backslash
      put_text("{==\\=}");
      // comment, then a lone brace at the end
      put_text("{##}{");
      finish_text();
      // unclosed region at the end yields only the end marker
      put_text("{{z");
      finish_text();
      directed_count = template_bytes.size();
      while (template_bytes.size() < directed_count + RANDOM_ITEMS) put_template();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (template_bytes.size() != 0) begin
         burst = $urandom_range(1, 40);
         while (burst > 0 && template_bytes.size() != 0) begin
            offer_item(template_bytes.pop_front());
            burst--;
         end
         if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 8);
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;

      while (tracker.rendered_q.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (tracker.errors == 0 && tracker.rendered_q.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/tts_pkg.sv
rtl/tts_front.sv
rtl/tts_queue.sv
rtl/tts_back.sv
rtl/template_tag_stripper_unit.sv
bench/tb_top.sv
